@@ hdl/sal_pkg.sv @@
// sal_pkg: shared types and constants of the set-associative LRU cache model.
// Depends on nothing; used by every module in hdl.
package sal_pkg;

	localparam int MAX_SETS_DEF = 256;
	localparam int MAX_WAYS_DEF = 8;
	localparam int TAG_W        = 64;
	localparam int STAMP_W      = 32;
	localparam int CNT_W        = 32;
	localparam int RES_W        = 24;
	localparam int CFG_W        = 4;
	localparam int CFG_IDX_W    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

	// access kinds
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_STORE = 1'b1;

	typedef struct packed {
		logic        func;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic              was_hit;
		logic              was_eviction;
		logic              victim_dirty;
		logic [CNT_W-1:0]  hit_total;
		logic [CNT_W-1:0]  miss_total;
		logic [CNT_W-1:0]  eviction_total;
		logic [CNT_W-1:0]  dirty_evicted_bytes;
		logic [RES_W-1:0]  dirty_resident_bytes;
	} rsp_t;

	// one cache line as held in the store
	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	// outcome of one lookup, towards the counters
	typedef struct packed {
		logic hit;
		logic evict;
		logic vdirty;
		logic dirty_inc;
		logic dirty_dec;
	} pick_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
		sat_inc = (a == '1) ? a : a + 1'b1;
	endfunction

endpackage

@@ hdl/sal_store.sv @@
// sal_store: line store, one row of all ways per set, registered read.
// Sweeps every row to zero after reset. Depends on sal_pkg.
module sal_store #(
	parameter int MAX_SETS = sal_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = sal_pkg::MAX_WAYS_DEF,
	localparam int AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [AW-1:0]                        rd_addr,
	output sal_pkg::line_t [MAX_WAYS-1:0]        rd_row,
	input  logic                                 wr_en,
	input  logic [AW-1:0]                        wr_addr,
	input  sal_pkg::line_t [MAX_WAYS-1:0]        wr_row,
	output logic                                 clearing
);

	sal_pkg::line_t [MAX_WAYS-1:0] mem [MAX_SETS];
	sal_pkg::line_t [MAX_WAYS-1:0] rd_row_q;
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;

	// clearing sweep, one row a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(MAX_SETS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// array write and registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	assign rd_row   = rd_row_q;
	assign clearing = clearing_q;

endmodule

@@ hdl/sal_pick.sv @@
// sal_pick: hit search, victim choice and the updated row for one access.
// Purely combinational. Depends on sal_pkg.
module sal_pick #(
	parameter int MAX_WAYS = sal_pkg::MAX_WAYS_DEF
) (
	input  sal_pkg::line_t [MAX_WAYS-1:0]  row,
	input  logic [sal_pkg::TAG_W-1:0]      tag,
	input  logic [4:0]                     ways,
	input  logic                           store,
	input  logic [sal_pkg::STAMP_W-1:0]    stamp,
	output sal_pkg::line_t [MAX_WAYS-1:0]  new_row,
	output sal_pkg::pick_t                 pick
);

	localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	logic                          hit;
	logic [WW-1:0]                 hit_way;
	logic                          found;
	logic [WW-1:0]                 inv_way;
	logic [WW-1:0]                 lru_way;
	logic [sal_pkg::STAMP_W-1:0]   best;
	logic [WW-1:0]                 way;
	sal_pkg::line_t                old;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		found   = 1'b0;
		inv_way = '0;
		lru_way = '0;
		best    = row[0].stamp;
		// first matching, first invalid and least recently used way among those in use
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (5'(w) < ways) begin
				if (!hit && row[w].valid && row[w].tag == tag) begin
					hit     = 1'b1;
					hit_way = WW'(w);
				end
				if (!found && !row[w].valid) begin
					found   = 1'b1;
					inv_way = WW'(w);
				end
				// strict less keeps ties on the lowest way
				if (w > 0 && row[w].stamp < best) begin
					best    = row[w].stamp;
					lru_way = WW'(w);
				end
			end
		end
	end

	always_comb begin
		way = hit ? hit_way : (found ? inv_way : lru_way);
		old = row[way];
		new_row = row;
		new_row[way].stamp = stamp;
		if (hit) begin
			new_row[way].dirty = old.dirty | store;
		end else begin
			new_row[way].valid = 1'b1;
			new_row[way].tag   = tag;
			new_row[way].dirty = store;
		end
		pick.hit       = hit;
		pick.evict     = !hit && !found;
		pick.vdirty    = !hit && !found && old.dirty;
		pick.dirty_inc = store && !(hit && old.dirty);
		pick.dirty_dec = !hit && old.dirty;
	end

endmodule

@@ hdl/set_assoc_lru_cache_model.sv @@
// set_assoc_lru_cache_model: top level of the LRU cache model, holds control,
// configuration and counters. Depends on sal_pkg, sal_store, sal_pick.
//
//   port group          dir  handshake
//   start/req/busy      in   taken at an edge with start high and busy low
//   done/rsp            out  one-cycle strobe, no back-pressure
//   cfg_we/idx/data     in   write at every edge with cfg_we high
//
// Each request passes two steps: the row read of its set, then the update and
// write-back of that row; the result strobes in the cycle after, when busy is
// already low again. After reset busy stays high while the store is swept
// clear. The receiver cannot stall; nothing waits on it.
module set_assoc_lru_cache_model #(
	parameter int MAX_SETS = sal_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = sal_pkg::MAX_WAYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  sal_pkg::req_t                   req,
	output logic                            busy,
	output logic                            done,
	output sal_pkg::rsp_t                   rsp,
	input  logic                            cfg_we,
	input  logic [sal_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [sal_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int KMAX = $clog2(MAX_SETS + 1) - 1;
	localparam int DCW  = $clog2(MAX_SETS * MAX_WAYS + 1);

	typedef enum logic {ST_IDLE, ST_LOOKUP} state_t;

	state_t state_q;
	logic [sal_pkg::CFG_W-1:0] set_bits_q, off_bits_q, ways_cfg_q;
	logic                            store_s1;
	logic [sal_pkg::TAG_W-1:0]       tag_s1;
	logic [AW-1:0]                   set_s1;
	logic [4:0]                      ways_s1;
	logic [sal_pkg::STAMP_W-1:0]     acc_q;
	logic [sal_pkg::CNT_W-1:0]       hit_q, miss_q, evict_q, debytes_q;
	logic [DCW-1:0]                  dcnt_q;
	logic                            done_q;
	sal_pkg::rsp_t                   rsp_q;

	logic                            clearing;
	logic                            accept;
	logic [sal_pkg::CFG_W-1:0]       sb;
	logic [AW-1:0]                   set_idx;
	logic [sal_pkg::TAG_W-1:0]       tag;
	logic [4:0]                      ways;
	logic [sal_pkg::STAMP_W-1:0]     stamp;
	sal_pkg::line_t [MAX_WAYS-1:0]   rd_row, new_row;
	sal_pkg::pick_t                  pick;
	logic [sal_pkg::CNT_W-1:0]       block;
	logic [sal_pkg::CNT_W-1:0]       debytes_sum;
	logic [sal_pkg::CNT_W:0]         debytes_wide;
	logic [DCW-1:0]                  dcnt_next;
	logic [sal_pkg::CNT_W+15:0]      resident;

	assign busy   = clearing || (state_q != ST_IDLE);
	assign accept = start && !busy;

	// geometry of the incoming request
	always_comb begin
		sb      = (set_bits_q > sal_pkg::CFG_W'(KMAX)) ? sal_pkg::CFG_W'(KMAX) : set_bits_q;
		set_idx = AW'(req.address >> off_bits_q) & AW'(({AW+1{1'b0}} | (AW+1)'(1)) << sb) - AW'(1);
		tag     = req.address >> (5'(sb) + 5'(off_bits_q));
		if (ways_cfg_q == '0) begin
			ways = 5'd1;
		end else if (5'(ways_cfg_q) > 5'(MAX_WAYS)) begin
			ways = 5'(MAX_WAYS);
		end else begin
			ways = 5'(ways_cfg_q);
		end
	end

	sal_store #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (set_idx),
		.rd_row   (rd_row),
		.wr_en    (state_q == ST_LOOKUP),
		.wr_addr  (set_s1),
		.wr_row   (new_row),
		.clearing (clearing)
	);

	assign stamp = sal_pkg::sat_inc(acc_q);

	sal_pick #(.MAX_WAYS(MAX_WAYS)) u_pick (
		.row     (rd_row),
		.tag     (tag_s1),
		.ways    (ways_s1),
		.store   (store_s1),
		.stamp   (stamp),
		.new_row (new_row),
		.pick    (pick)
	);

	// counter arithmetic for the lookup cycle
	always_comb begin
		block        = sal_pkg::CNT_W'(1) << off_bits_q;
		debytes_wide = {1'b0, debytes_q} + {1'b0, block};
		debytes_sum  = debytes_wide[sal_pkg::CNT_W] ? '1 : debytes_wide[sal_pkg::CNT_W-1:0];
		dcnt_next    = dcnt_q + DCW'(pick.dirty_inc) - DCW'(pick.dirty_dec);
		resident     = (sal_pkg::CNT_W+16)'(dcnt_next) << off_bits_q;
	end

	// control, configuration, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			set_bits_q <= '0;
			off_bits_q <= '0;
			ways_cfg_q <= sal_pkg::CFG_W'(1);
			acc_q      <= '0;
			hit_q      <= '0;
			miss_q     <= '0;
			evict_q    <= '0;
			debytes_q  <= '0;
			dcnt_q     <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= (state_q == ST_LOOKUP);
			if (cfg_we) begin
				unique case (cfg_idx)
					sal_pkg::CFG_SET_BITS: set_bits_q <= cfg_data;
					sal_pkg::CFG_OFF_BITS: off_bits_q <= cfg_data;
					sal_pkg::CFG_WAYS:     ways_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
					acc_q   <= stamp;
					dcnt_q  <= dcnt_next;
					if (pick.hit) begin
						hit_q <= sal_pkg::sat_inc(hit_q);
					end else begin
						miss_q <= sal_pkg::sat_inc(miss_q);
					end
					if (pick.evict) begin
						evict_q <= sal_pkg::sat_inc(evict_q);
					end
					if (pick.vdirty) begin
						debytes_q <= debytes_sum;
					end
					rsp_q.was_hit             <= pick.hit;
					rsp_q.was_eviction        <= pick.evict;
					rsp_q.victim_dirty        <= pick.vdirty;
					rsp_q.hit_total           <= pick.hit ? sal_pkg::sat_inc(hit_q) : hit_q;
					rsp_q.miss_total          <= pick.hit ? miss_q : sal_pkg::sat_inc(miss_q);
					rsp_q.eviction_total      <= pick.evict ? sal_pkg::sat_inc(evict_q) : evict_q;
					rsp_q.dirty_evicted_bytes <= pick.vdirty ? debytes_sum : debytes_q;
					rsp_q.dirty_resident_bytes <= (resident > (sal_pkg::CNT_W+16)'(24'hFFFFFF))
						? '1 : resident[sal_pkg::RES_W-1:0];
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields held for the lookup
	always_ff @(posedge clk) begin
		if (accept) begin
			store_s1 <= (req.func == sal_pkg::FUNC_STORE);
			tag_s1   <= tag;
			set_s1   <= set_idx;
			ways_s1  <= ways;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ hdl/sal_checker.sv @@
// sal_checker: port-level assertions for the cache model, bound to the top.
// Depends on sal_pkg and set_assoc_lru_cache_model.
module sal_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input sal_pkg::rsp_t rsp
);

	// every accepted request yields a result strobe
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done) else $error("request gave no result");

	// an accepted request holds the block busy in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");

	// results never come in consecutive cycles
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");

	// a hit never evicts
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.was_hit) |-> (!rsp.was_eviction && !rsp.victim_dirty))
		else $error("hit reported an eviction");

	// a dirty victim implies an eviction
	a_vd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.victim_dirty) |-> rsp.was_eviction)
		else $error("dirty victim without eviction");

endmodule

bind set_assoc_lru_cache_model sal_checker u_sal_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
